>>> rtl/lmt_pkg.sv
// ----------------------------------------------------------------------------
// lmt_pkg: shared types and constants of the lcd mode timer
// Operation codes, register indexes, line timing constants and the structs
// passed between the control unit, the two memories and the top level.
// ----------------------------------------------------------------------------
package lmt_pkg;

   // line and frame timing
   localparam logic [9:0] LineDots    = 10'd456;
   localparam logic [9:0] Mode0End    = 10'd205;
   localparam logic [9:0] Mode2End    = 10'd285;
   localparam logic [7:0] VblankLine  = 8'd144;
   localparam logic [7:0] LineCount   = 8'd154;

   // memory sizes and address limits
   localparam int unsigned VramDepth  = 8192;
   localparam int unsigned VramAw     = $clog2(VramDepth);
   localparam int unsigned OamDepth   = 160;
   localparam int unsigned OamAw      = $clog2(OamDepth);
   localparam logic [15:0] VramMax    = 16'h1FFF;
   localparam logic [15:0] OamMax     = 16'h009F;
   localparam logic [15:0] RegFirst   = 16'hFF40;
   localparam logic [15:0] RegLast    = 16'hFF4B;
   localparam logic [7:0]  StatWrMask = 8'hF8;
   localparam logic [7:0]  BlockedRd  = 8'hFF;

   // bus operations
   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_REG_RD   = 3'd1,
      OP_REG_WR   = 3'd2,
      OP_VRAM_RD  = 3'd3,
      OP_VRAM_WR  = 3'd4,
      OP_OAM_RD   = 3'd5,
      OP_OAM_WR   = 3'd6
   } op_type;

   // register index, low nibble of the bus address
   typedef enum logic [3:0] {
      REG_LCDC = 4'd0,
      REG_STAT = 4'd1,
      REG_SCY  = 4'd2,
      REG_SCX  = 4'd3,
      REG_LY   = 4'd4,
      REG_LYC  = 4'd5,
      REG_DMA  = 4'd6,
      REG_BGP  = 4'd7,
      REG_OBP0 = 4'd8,
      REG_OBP1 = 4'd9,
      REG_WY   = 4'd10,
      REG_WX   = 4'd11
   } reg_index_type;

   // source of the read byte of a result
   typedef enum logic [1:0] {
      SRC_CONST = 2'd0,
      SRC_VRAM  = 2'd1,
      SRC_OAM   = 2'd2
   } rd_src_type;

   // one accepted input item
   typedef struct packed {
      op_type      op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  tick_cycles;
   } req_item_type;

   // access to one memory
   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [VramAw-1:0] addr;
      logic [7:0]        wdata;
   } mem_req_type;

   // result fields known at execute time
   typedef struct packed {
      rd_src_type src;
      logic [7:0] data;
      logic       status;
      logic       irq_vblank;
      logic       irq_lcd_stat;
   } rsp_info_type;

endpackage

>>> rtl/lcd_mode_timer_with_vram_gate_core.sv
// ----------------------------------------------------------------------------
// lcd_mode_timer_with_vram_gate_core: tile display timing and bus interface
// Register, video memory and sprite memory accesses plus timer ticks, one
// result per item, with mode based gating of both memories.
//
//   channel | dir | tdata (low bit up)                   | tuser
//   --------+-----+--------------------------------------+-----------------
//   req     | in  | address 16, write_data 8, tick_cyc 8 | op 3
//   rsp     | out | read_data 8, irq_vblank, irq_lcd_stat| status 1
//
// One item per cycle sustained while the result side accepts; each item passes
// the input register, then the memory read and result register, before its
// result appears. After reset the video memory is cleared, one byte a cycle;
// req_tready stays low until that pass ends.
// A stalled result holds the execute stage; req_tready follows rsp_tready
// only when the input register is already full.
// ----------------------------------------------------------------------------
module lcd_mode_timer_with_vram_gate_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // address[15:0], write_data[23:16], tick_cycles[31:24]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // read_data[7:0], irq_vblank[8], irq_lcd_stat[9], zero
   output logic        rsp_tuser    // status[0]
);
   import lmt_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_item_ff;
   logic         s2_valid_ff, s2_valid_in;
   rsp_info_type s2_info_ff;
   logic         go;
   logic         req_xfer;
   logic         vram_busy;
   logic [7:0]   vram_rdata;
   logic [7:0]   oam_rdata;
   logic [7:0]   rd_byte;
   mem_req_type  vram_req;
   mem_req_type  oam_req;
   rsp_info_type info;

   // handshake and stage advance
   always_comb begin
      go          = s1_valid_ff && (!s2_valid_ff || rsp_tready);
      req_tready  = !vram_busy && (!s1_valid_ff || go);
      req_xfer    = req_tvalid && req_tready;
      s1_valid_in = req_xfer || (s1_valid_ff && !go);
      s2_valid_in = go || (s2_valid_ff && !rsp_tready);
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_item_ff.op          <= op_type'(req_tuser);
         s1_item_ff.address     <= req_tdata[15:0];
         s1_item_ff.write_data  <= req_tdata[23:16];
         s1_item_ff.tick_cycles <= req_tdata[31:24];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (go) begin
         s2_info_ff <= info;
      end
   end

   lmt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .item     (s1_item_ff),
      .vram_req (vram_req),
      .oam_req  (oam_req),
      .info     (info)
   );

   lmt_vram u_vram (
      .clock (clock),
      .reset (reset),
      .req   (vram_req),
      .busy  (vram_busy),
      .rdata (vram_rdata)
   );

   lmt_oam u_oam (
      .clock (clock),
      .reset (reset),
      .req   (oam_req),
      .rdata (oam_rdata)
   );

   // read byte select
   always_comb begin
      unique case (s2_info_ff.src)
         SRC_VRAM: rd_byte = vram_rdata;
         SRC_OAM:  rd_byte = oam_rdata;
         default:  rd_byte = s2_info_ff.data;
      endcase
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {6'b000000, s2_info_ff.irq_lcd_stat, s2_info_ff.irq_vblank, rd_byte};
   assign rsp_tuser  = s2_info_ff.status;

endmodule

>>> rtl/lmt_vram.sv
// ----------------------------------------------------------------------------
// lmt_vram: video memory with a clearing pass after reset
// 8192 bytes, one write and one registered read a cycle. After reset the
// memory is swept to zero, one byte a cycle, while busy is high.
// ----------------------------------------------------------------------------
module lmt_vram (
   input  logic                 clock,
   input  logic                 reset,
   input  lmt_pkg::mem_req_type req,
   output logic                 busy,
   output logic [7:0]           rdata
);
   import lmt_pkg::*;

   logic [7:0]        mem [0:VramDepth-1];
   logic [7:0]        rdata_ff;
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [VramAw-1:0] clr_cnt_ff;
   logic [VramAw-1:0] clr_cnt_in;
   logic              wr_en;
   logic [VramAw-1:0] wr_addr;
   logic [7:0]        wr_data;

   // clearing sweep control
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == VramAw'(VramDepth - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // write port shared by the sweep and bus writes
   always_comb begin
      wr_en   = clr_busy_ff | req.wr_en;
      wr_addr = clr_busy_ff ? clr_cnt_ff : req.addr;
      wr_data = clr_busy_ff ? 8'h00 : req.wdata;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rdata_ff <= mem[req.addr];
      end
   end

   assign busy  = clr_busy_ff;
   assign rdata = rdata_ff;

endmodule

>>> rtl/lmt_oam.sv
// ----------------------------------------------------------------------------
// lmt_oam: sprite memory with per-entry valid bits
// 160 bytes, one write and one registered read a cycle. Valid bits clear at
// reset so that an entry not yet written reads as zero.
// ----------------------------------------------------------------------------
module lmt_oam (
   input  logic                 clock,
   input  logic                 reset,
   input  lmt_pkg::mem_req_type req,
   output logic [7:0]           rdata
);
   import lmt_pkg::*;

   logic [7:0]          mem [0:OamDepth-1];
   logic [OamDepth-1:0] valid_ff;
   logic [7:0]          rdata_ff;
   logic                rvalid_ff;
   logic [OamAw-1:0]    addr;

   assign addr = req.addr[OamAw-1:0];

   // valid bits, set on first write
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[addr] <= 1'b1;
      end
   end

   // storage write
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[addr] <= req.wdata;
      end
   end

   // registered read with its valid bit
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rdata_ff  <= mem[addr];
         rvalid_ff <= valid_ff[addr];
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : 8'h00;

endmodule

>>> rtl/lmt_ctrl.sv
// ----------------------------------------------------------------------------
// lmt_ctrl: register file, line timer and memory gating
// Executes one item per cycle when go is high: advances the dot and line
// counters on ticks, reads and writes the registers (the dma index reads zero
// and keeps no write), and issues gated video and sprite memory accesses.
// ----------------------------------------------------------------------------
module lmt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  lmt_pkg::req_item_type item,
   output lmt_pkg::mem_req_type  vram_req,
   output lmt_pkg::mem_req_type  oam_req,
   output lmt_pkg::rsp_info_type info
);
   import lmt_pkg::*;

   logic [7:0] lcdc_ff, lcdc_in;
   logic [7:0] stat_ff, stat_in;
   logic [7:0] scy_ff, scy_in;
   logic [7:0] scx_ff, scx_in;
   logic [7:0] ly_ff, ly_in;
   logic [7:0] lyc_ff, lyc_in;
   logic [7:0] bgp_ff, bgp_in;
   logic [7:0] obp0_ff, obp0_in;
   logic [7:0] obp1_ff, obp1_in;
   logic [7:0] wy_ff, wy_in;
   logic [7:0] wx_ff, wx_in;
   logic [9:0] dot_ff, dot_in;

   // tick results
   logic [9:0] t_sum;
   logic [9:0] t_dot;
   logic [7:0] t_line;
   logic [7:0] t_stat;
   logic       t_irq_v;
   logic       t_irq_l;

   logic          reg_ok;
   logic          vram_ok;
   logic          oam_ok;
   logic          vram_closed;
   logic          oam_closed;
   reg_index_type ridx;
   logic [7:0]    reg_rd;

   // tick: dot counter, line advance, coincidence and mode
   always_comb begin
      t_sum   = dot_ff + {2'b00, item.tick_cycles};
      t_dot   = t_sum;
      t_line  = ly_ff;
      t_stat  = stat_ff;
      t_irq_v = 1'b0;
      t_irq_l = 1'b0;
      if (t_sum > LineDots) begin
         t_dot  = t_sum - LineDots;
         t_line = ly_ff + 8'd1;
         if (t_line == VblankLine) begin
            t_stat  = {t_stat[7:2], 2'b01};
            t_irq_v = 1'b1;
            if (t_stat[4]) t_irq_l = 1'b1;
         end else if (t_line == LineCount) begin
            t_line = 8'd0;
         end
         if (t_line == lyc_ff) begin
            t_stat[2] = 1'b1;
            if (t_stat[6]) t_irq_l = 1'b1;
         end else begin
            t_stat[2] = 1'b0;
         end
      end
      if (t_line < VblankLine) begin
         if (t_dot < Mode0End) begin
            t_stat[1:0] = 2'b00;
            if (t_stat[3]) t_irq_l = 1'b1;
         end else if (t_dot < Mode2End) begin
            t_stat[1:0] = 2'b10;
            if (t_stat[5]) t_irq_l = 1'b1;
         end else begin
            t_stat[1:0] = 2'b11;
         end
      end
   end

   // address decode and mode gating
   always_comb begin
      reg_ok      = (item.address >= RegFirst) && (item.address <= RegLast);
      vram_ok     = item.address <= VramMax;
      oam_ok      = item.address <= OamMax;
      vram_closed = lcdc_ff[7] && (stat_ff[1:0] == 2'b11);
      oam_closed  = lcdc_ff[7] && stat_ff[1];
      ridx        = reg_index_type'(item.address[3:0]);
   end

   // register read mux
   always_comb begin
      unique case (ridx)
         REG_LCDC: reg_rd = lcdc_ff;
         REG_STAT: reg_rd = stat_ff;
         REG_SCY:  reg_rd = scy_ff;
         REG_SCX:  reg_rd = scx_ff;
         REG_LY:   reg_rd = ly_ff;
         REG_LYC:  reg_rd = lyc_ff;
         REG_BGP:  reg_rd = bgp_ff;
         REG_OBP0: reg_rd = obp0_ff;
         REG_OBP1: reg_rd = obp1_ff;
         REG_WY:   reg_rd = wy_ff;
         REG_WX:   reg_rd = wx_ff;
         default:  reg_rd = 8'h00;
      endcase
   end

   // execute: next state, memory requests and result fields
   always_comb begin
      lcdc_in = lcdc_ff;
      stat_in = stat_ff;
      scy_in  = scy_ff;
      scx_in  = scx_ff;
      ly_in   = ly_ff;
      lyc_in  = lyc_ff;
      bgp_in  = bgp_ff;
      obp0_in = obp0_ff;
      obp1_in = obp1_ff;
      wy_in   = wy_ff;
      wx_in   = wx_ff;
      dot_in  = dot_ff;

      vram_req.rd_en = 1'b0;
      vram_req.wr_en = 1'b0;
      vram_req.addr  = item.address[VramAw-1:0];
      vram_req.wdata = item.write_data;
      oam_req.rd_en  = 1'b0;
      oam_req.wr_en  = 1'b0;
      oam_req.addr   = item.address[VramAw-1:0];
      oam_req.wdata  = item.write_data;

      info.src          = SRC_CONST;
      info.data         = 8'h00;
      info.status       = 1'b0;
      info.irq_vblank   = 1'b0;
      info.irq_lcd_stat = 1'b0;

      unique case (item.op)
         OP_TICK: begin
            info.irq_vblank   = t_irq_v;
            info.irq_lcd_stat = t_irq_l;
            if (go) begin
               stat_in = t_stat;
               ly_in   = t_line;
               dot_in  = t_dot;
            end
         end
         OP_REG_RD: begin
            if (reg_ok) info.data = reg_rd;
            else info.status = 1'b1;
         end
         OP_REG_WR: begin
            if (!reg_ok) begin
               info.status = 1'b1;
            end else if (go) begin
               // the page written to the dma register has no copy engine here
               unique case (ridx)
                  REG_LCDC: lcdc_in = item.write_data;
                  REG_STAT: stat_in = (item.write_data & StatWrMask)
                                      | (stat_ff & ~StatWrMask);
                  REG_SCY:  scy_in  = item.write_data;
                  REG_SCX:  scx_in  = item.write_data;
                  REG_LY:   ly_in   = 8'd0;
                  REG_LYC:  lyc_in  = item.write_data;
                  REG_BGP:  bgp_in  = item.write_data;
                  REG_OBP0: obp0_in = item.write_data;
                  REG_OBP1: obp1_in = item.write_data;
                  REG_WY:   wy_in   = item.write_data;
                  REG_WX:   wx_in   = item.write_data;
                  default:  ;
               endcase
            end
         end
         OP_VRAM_RD: begin
            if (!vram_ok) begin
               info.status = 1'b1;
            end else if (vram_closed) begin
               info.data = BlockedRd;
            end else begin
               info.src       = SRC_VRAM;
               vram_req.rd_en = go;
            end
         end
         OP_VRAM_WR: begin
            if (!vram_ok) info.status = 1'b1;
            else vram_req.wr_en = go && !vram_closed;
         end
         OP_OAM_RD: begin
            if (!oam_ok) begin
               info.status = 1'b1;
            end else if (oam_closed) begin
               info.data = BlockedRd;
            end else begin
               info.src      = SRC_OAM;
               oam_req.rd_en = go;
            end
         end
         OP_OAM_WR: begin
            if (!oam_ok) info.status = 1'b1;
            else oam_req.wr_en = go && !oam_closed;
         end
         default: ;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lcdc_ff <= 8'h00;
         stat_ff <= 8'h00;
         scy_ff  <= 8'h00;
         scx_ff  <= 8'h00;
         ly_ff   <= 8'h00;
         lyc_ff  <= 8'h00;
         bgp_ff  <= 8'h00;
         obp0_ff <= 8'hFF;
         obp1_ff <= 8'hFF;
         wy_ff   <= 8'h00;
         wx_ff   <= 8'h00;
         dot_ff  <= 10'd0;
      end else begin
         lcdc_ff <= lcdc_in;
         stat_ff <= stat_in;
         scy_ff  <= scy_in;
         scx_ff  <= scx_in;
         ly_ff   <= ly_in;
         lyc_ff  <= lyc_in;
         bgp_ff  <= bgp_in;
         obp0_ff <= obp0_in;
         obp1_ff <= obp1_in;
         wy_ff   <= wy_in;
         wx_ff   <= wx_in;
         dot_ff  <= dot_in;
      end
   end

`ifndef SYNTH
   // dot counter never passes one line length
   a_dot_range: assert property (@(posedge clock) disable iff (reset)
      dot_ff <= LineDots)
      else $error("dot counter beyond line length");

   // lines in vertical blank always show mode 1
   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      (ly_ff >= VblankLine) |-> (ly_ff < LineCount) && (stat_ff[1:0] == 2'b01))
      else $error("line count or mode wrong in vertical blank");

   // memories are touched only when the item executes
   a_mem_on_go: assert property (@(posedge clock) disable iff (reset)
      !go |-> !(vram_req.rd_en || vram_req.wr_en || oam_req.rd_en || oam_req.wr_en))
      else $error("memory access without an executing item");
`endif

endmodule

>>> bench/lcd_mode_timer_with_vram_gate_core_tb.sv
// ----------------------------------------------------------------------------
// lcd_mode_timer_with_vram_gate_core_tb: self-checking bench of the lcd timer
// Runs a short table of directed bus accesses and ticks, then a long random
// mix dominated by ticks, so that the line count passes vertical blank and
// wraps. Every result transfer is compared field by field with the oldest
// reply, typed in the table or worked out by a local copy of the timer,
// registers and both memories. Both sides idle at random in the first two phases.
// ----------------------------------------------------------------------------
module lcd_mode_timer_with_vram_gate_core_tb;
   import lmt_pkg::*;

   // status mode codes and status register bit positions
   localparam logic [1:0] ModeHblank   = 2'd0;
   localparam logic [1:0] ModeVblank   = 2'd1;
   localparam logic [1:0] ModeOamScan  = 2'd2;
   localparam logic [1:0] ModeTransfer = 2'd3;
   localparam int         StatCoinFlag = 2;
   localparam int         StatIeHblank = 3;
   localparam int         StatIeVblank = 4;
   localparam int         StatIeOam    = 5;
   localparam int         StatIeCoin   = 6;
   localparam int         LcdOnBit     = 7;
   localparam logic       StatusOk     = 1'b0;
   localparam logic       StatusRange  = 1'b1;
   localparam int         QuietLimit   = 40000;
   localparam int         PhaseItems   = 192;
   localparam int         TableRows    = 26;

   // fields of one result transfer
   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
      logic       irq_vblank;
      logic       irq_lcd_stat;
   } reply_type;

   // one row of the directed table
   typedef struct {
      op_type      op;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  tick_cycles;
      bit          typed;
      logic [7:0]  typed_data;
      logic        typed_status;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // address[15:0], write_data[23:16], tick_cycles[31:24]
   logic [2:0]  req_tuser = '0;   // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // read_data[7:0], irq_vblank[8], irq_lcd_stat[9], zero
   logic        rsp_tuser;        // status[0]

   // local copy of the display state
   logic [7:0] shadow_regs [12];
   logic [9:0] shadow_dots;
   logic [7:0] shadow_vram [VramDepth];
   logic [7:0] shadow_oam  [OamDepth];

   reply_type     expected_replies [$];
   table_row_type access_table [TableRows];
   int            send_idle_pct = 33;
   int            recv_idle_pct = 73;
   int            error_count = 0;
   int            quiet_cycles = 0;

   lcd_mode_timer_with_vram_gate_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // reply of one item; advances the local display state
   function automatic reply_type bus_reply(req_item_type it);
      reply_type     r;
      logic          in_regs;
      logic          vram_shut;
      logic          oam_shut;
      reg_index_type idx;
      r = '0;
      in_regs = it.address >= RegFirst && it.address <= RegLast;
      idx = reg_index_type'(it.address[3:0]);
      vram_shut = shadow_regs[REG_LCDC][LcdOnBit] && shadow_regs[REG_STAT][1:0] == ModeTransfer;
      oam_shut = shadow_regs[REG_LCDC][LcdOnBit] && shadow_regs[REG_STAT][1];
      case (it.op)
         OP_TICK: begin
            shadow_dots = shadow_dots + 10'(it.tick_cycles);
            // line advance, vertical blank entry and frame wrap
            if (shadow_dots > LineDots) begin
               shadow_dots = shadow_dots - LineDots;
               shadow_regs[REG_LY] = shadow_regs[REG_LY] + 8'd1;
               if (shadow_regs[REG_LY] == VblankLine) begin
                  shadow_regs[REG_STAT][1:0] = ModeVblank;
                  r.irq_vblank = 1'b1;
                  if (shadow_regs[REG_STAT][StatIeVblank]) r.irq_lcd_stat = 1'b1;
               end else if (shadow_regs[REG_LY] == LineCount) begin
                  shadow_regs[REG_LY] = 8'd0;
               end
               if (shadow_regs[REG_LY] == shadow_regs[REG_LYC]) begin
                  shadow_regs[REG_STAT][StatCoinFlag] = 1'b1;
                  if (shadow_regs[REG_STAT][StatIeCoin]) r.irq_lcd_stat = 1'b1;
               end else begin
                  shadow_regs[REG_STAT][StatCoinFlag] = 1'b0;
               end
            end
            // visible lines: mode follows the dot count
            if (shadow_regs[REG_LY] < VblankLine) begin
               if (shadow_dots < Mode0End) begin
                  shadow_regs[REG_STAT][1:0] = ModeHblank;
                  if (shadow_regs[REG_STAT][StatIeHblank]) r.irq_lcd_stat = 1'b1;
               end else if (shadow_dots < Mode2End) begin
                  shadow_regs[REG_STAT][1:0] = ModeOamScan;
                  if (shadow_regs[REG_STAT][StatIeOam]) r.irq_lcd_stat = 1'b1;
               end else begin
                  shadow_regs[REG_STAT][1:0] = ModeTransfer;
               end
            end
         end
         OP_REG_RD: begin
            if (!in_regs) r.status = StatusRange;
            else if (idx != REG_DMA) r.read_data = shadow_regs[idx];
         end
         OP_REG_WR: begin
            if (!in_regs) begin
               r.status = StatusRange;
            end else begin
               case (idx)
                  REG_STAT: shadow_regs[REG_STAT] = (it.write_data & StatWrMask)
                                                  | (shadow_regs[REG_STAT] & ~StatWrMask);
                  REG_LY:   shadow_regs[REG_LY] = 8'd0;
                  default:  shadow_regs[idx] = it.write_data;
               endcase
            end
         end
         OP_VRAM_RD: begin
            if (it.address > VramMax) r.status = StatusRange;
            else r.read_data = vram_shut ? BlockedRd : shadow_vram[it.address[VramAw-1:0]];
         end
         OP_VRAM_WR: begin
            if (it.address > VramMax) r.status = StatusRange;
            else if (!vram_shut) shadow_vram[it.address[VramAw-1:0]] = it.write_data;
         end
         OP_OAM_RD: begin
            if (it.address > OamMax) r.status = StatusRange;
            else r.read_data = oam_shut ? BlockedRd : shadow_oam[it.address[7:0]];
         end
         OP_OAM_WR: begin
            if (it.address > OamMax) r.status = StatusRange;
            else if (!oam_shut) shadow_oam[it.address[7:0]] = it.write_data;
         end
         default: ;
      endcase
      return r;
   endfunction

   // drive one item, hold it until the transfer, then queue its reply
   task automatic send_item(req_item_type it, bit typed, reply_type typed_reply);
      reply_type r;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.tick_cycles, it.write_data, it.address};
      req_tuser  <= it.op;
      do @(posedge clock); while (!req_tready);
      r = bus_reply(it);
      expected_replies.push_back(typed ? typed_reply : r);
   endtask

   // hold off the sender until every queued reply has come back
   task automatic wait_replies_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_replies.size() != 0);
   endtask

   task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   // receiver stalls
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // compare each result transfer with the oldest queued reply
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected result expected none actual %0h/%0h",
                     $time, rsp_tdata, rsp_tuser);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            check_field("read_data", want.read_data, rsp_tdata[7:0]);
            check_field("status", 8'(want.status), 8'(rsp_tuser));
            check_field("irq_vblank", 8'(want.irq_vblank), 8'(rsp_tdata[8]));
            check_field("irq_lcd_stat", 8'(want.irq_lcd_stat), 8'(rsp_tdata[9]));
         end
      end
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // stimulus
   initial begin
      req_item_type it;
      reply_type    typed_reply;
      logic [15:0]  mem_max;
      int           pick;
      int           k;

      for (k = 0; k < 12; k++) shadow_regs[k] = 8'h00;
      shadow_regs[REG_OBP0] = 8'hFF;
      shadow_regs[REG_OBP1] = 8'hFF;
      shadow_dots = '0;
      for (k = 0; k < VramDepth; k++) shadow_vram[k] = 8'h00;
      for (k = 0; k < OamDepth; k++) shadow_oam[k] = 8'h00;

      access_table = '{
         // reset values and out of range addresses
         '{OP_REG_RD,  16'hFF40, 8'h00, 8'h00, 1'b1, 8'h00, StatusOk},
         '{OP_REG_RD,  16'hFF48, 8'h00, 8'h00, 1'b1, 8'hFF, StatusOk},
         '{OP_REG_RD,  16'hFF49, 8'h00, 8'h00, 1'b1, 8'hFF, StatusOk},
         '{OP_REG_RD,  16'hFF3F, 8'h00, 8'h00, 1'b1, 8'h00, StatusRange},
         '{OP_REG_WR,  16'hFF4C, 8'h55, 8'h00, 1'b1, 8'h00, StatusRange},
         '{OP_VRAM_RD, 16'h1FFF, 8'h00, 8'h00, 1'b1, 8'h00, StatusOk},
         '{OP_VRAM_RD, 16'h2000, 8'h00, 8'h00, 1'b1, 8'h00, StatusRange},
         '{OP_VRAM_WR, 16'hFFFF, 8'hA5, 8'h00, 1'b1, 8'h00, StatusRange},
         '{OP_OAM_RD,  16'h009F, 8'h00, 8'h00, 1'b1, 8'h00, StatusOk},
         '{OP_OAM_WR,  16'h00A0, 8'h5A, 8'h00, 1'b1, 8'h00, StatusRange},
         // dma page takes writes but reads back zero
         '{OP_REG_WR,  16'hFF46, 8'hAB, 8'h00, 1'b1, 8'h00, StatusOk},
         '{OP_REG_RD,  16'hFF46, 8'h00, 8'h00, 1'b1, 8'h00, StatusOk},
         // display off: both memories open
         '{OP_VRAM_WR, 16'h0000, 8'hFF, 8'h00, 1'b1, 8'h00, StatusOk},
         '{OP_VRAM_RD, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, StatusOk},
         '{OP_OAM_WR,  16'h0000, 8'h80, 8'h00, 1'b0, 8'h00, StatusOk},
         // status write keeps the low bits, all interrupt enables on
         '{OP_REG_WR,  16'hFF41, 8'hFF, 8'h00, 1'b0, 8'h00, StatusOk},
         '{OP_REG_WR,  16'hFF45, 8'h01, 8'h00, 1'b0, 8'h00, StatusOk},
         // oam scan, then line advance with coincidence
         '{OP_TICK,    16'h0000, 8'h00, 8'hFF, 1'b0, 8'h00, StatusOk},
         '{OP_TICK,    16'hFFFF, 8'hFF, 8'hFF, 1'b0, 8'h00, StatusOk},
         // display on, pixel transfer closes both memories
         '{OP_REG_WR,  16'hFF40, 8'h80, 8'h00, 1'b0, 8'h00, StatusOk},
         '{OP_TICK,    16'h0000, 8'h00, 8'hF0, 1'b0, 8'h00, StatusOk},
         '{OP_TICK,    16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, StatusOk},
         '{OP_VRAM_RD, 16'h0000, 8'h00, 8'h00, 1'b0, 8'h00, StatusOk},
         '{OP_OAM_WR,  16'h0001, 8'h11, 8'h00, 1'b0, 8'h00, StatusOk},
         // line register write clears it
         '{OP_REG_WR,  16'hFF44, 8'h77, 8'h00, 1'b0, 8'h00, StatusOk},
         '{OP_REG_RD,  16'hFF44, 8'h00, 8'h00, 1'b1, 8'h00, StatusOk}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (k = 0; k < TableRows; k++) begin
         it.op          = access_table[k].op;
         it.address     = access_table[k].address;
         it.write_data  = access_table[k].write_data;
         it.tick_cycles = access_table[k].tick_cycles;
         typed_reply    = '{access_table[k].typed_data, access_table[k].typed_status,
                            1'b0, 1'b0};
         send_item(it, access_table[k].typed, typed_reply);
      end
      wait_replies_drained();

      // random mix, mostly long ticks so that frames complete
      for (k = 0; k < 3 * PhaseItems; k++) begin
         if (k == PhaseItems) begin
            wait_replies_drained();
            send_idle_pct = 73;
            recv_idle_pct = 33;
         end else if (k == 2 * PhaseItems) begin
            wait_replies_drained();
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         it.address     = 16'($urandom);
         it.write_data  = 8'($urandom);
         it.tick_cycles = 8'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            it.op = OP_TICK;
            if ($urandom_range(0, 3) != 0) it.tick_cycles = 8'($urandom_range(180, 255));
         end else if (pick < 77) begin
            it.op = (pick < 71) ? OP_REG_RD : OP_REG_WR;
            if ($urandom_range(0, 9) != 0) it.address = RegFirst + 16'($urandom_range(0, 11));
            // clearing the line count is kept rare so that vertical blank is reached
            if (it.op == OP_REG_WR && it.address == {RegFirst[15:4], REG_LY}
                && $urandom_range(0, 7) != 0)
               it.address = {RegFirst[15:4], REG_STAT};
            if (it.address == {RegFirst[15:4], REG_LYC} && $urandom_range(0, 1) != 0)
               it.write_data = 8'($urandom_range(0, 153));
         end else begin
            case ($urandom_range(0, 3))
               0:       it.op = OP_VRAM_RD;
               1:       it.op = OP_VRAM_WR;
               2:       it.op = OP_OAM_RD;
               default: it.op = OP_OAM_WR;
            endcase
            mem_max = (it.op == OP_VRAM_RD || it.op == OP_VRAM_WR) ? VramMax : OamMax;
            pick = $urandom_range(0, 9);
            if (pick < 7) it.address = 16'($urandom_range(0, 15));
            else if (pick < 9) it.address = 16'($urandom_range(0, mem_max));
            else it.address = 16'($urandom_range(mem_max + 1, 16'hFFFF));
         end
         send_item(it, 1'b0, '0);
      end

      // drain and let the pipeline settle
      wait_replies_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
